// File: hdl/tss_pkg.sv
// shared types, constants and arithmetic helpers for the triangle scanline span block
// no dependencies; imported by every module under hdl
`timescale 1ns / 1ps

package tss_pkg;

  // coordinate format
  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 4;
  localparam int ROW_WIDTH   = 12;
  localparam int OUT_WIDTH   = 12;

  // derived widths
  localparam int EXT_WIDTH  = ((COORD_WIDTH > ROW_WIDTH + FRAC_BITS) ?
                               COORD_WIDTH : ROW_WIDTH + FRAC_BITS) + 2;
  localparam int DX_WIDTH   = COORD_WIDTH + 1;
  localparam int A_WIDTH    = COORD_WIDTH + 1;
  localparam int PROD_WIDTH = DX_WIDTH + A_WIDTH + 1;
  localparam int MAG_WIDTH  = 2 * COORD_WIDTH + 1;
  localparam int COL_WIDTH  = MAG_WIDTH + 2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

  localparam logic signed [EXT_WIDTH-1:0] HALF = EXT_WIDTH'(1 << (FRAC_BITS - 1));

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
    logic signed [ROW_WIDTH-1:0]   row;
  } in_req_t;

  typedef struct packed {
    logic                        covered;
    logic signed [OUT_WIDTH-1:0] span_left;
    logic signed [OUT_WIDTH-1:0] span_right;
  } out_rsp_t;

  // one edge evaluation: x = ax + dx * a / d
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [DX_WIDTH-1:0]    dx;
    logic [A_WIDTH-1:0]            a;
    logic [COORD_WIDTH-1:0]        d;
  } edge_t;

  typedef struct packed {
    logic  covered;
    edge_t lng;
    edge_t sht;
  } job_t;

  // divider state for one edge; nq holds numerator bits then quotient bits
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic [COORD_WIDTH-1:0]        d;
    logic                          neg;
    logic [COORD_WIDTH-1:0]        rem;
    logic [MAG_WIDTH-1:0]          nq;
  } div_edge_t;

  typedef struct packed {
    logic      covered;
    div_edge_t lng;
    div_edge_t sht;
  } div_t;

  // one restoring division step
  function automatic div_edge_t div_step(div_edge_t e);
    div_edge_t             r;
    logic [COORD_WIDTH:0]  rs;
    logic [COORD_WIDTH:0]  diff;
    logic                  ge;
    r    = e;
    rs   = {e.rem, e.nq[MAG_WIDTH-1]};
    diff = rs - {1'b0, e.d};
    ge   = (rs >= {1'b0, e.d});
    r.rem = ge ? diff[COORD_WIDTH-1:0] : rs[COORD_WIDTH-1:0];
    r.nq  = {e.nq[MAG_WIDTH-2:0], ge};
    return r;
  endfunction

  function automatic div_t div_all(div_t s);
    div_t r;
    r     = s;
    r.lng = div_step(s.lng);
    r.sht = div_step(s.sht);
    return r;
  endfunction

  // pixel column of a finished edge, truncated toward zero
  function automatic logic signed [COL_WIDTH-1:0] col_px(div_edge_t e);
    logic                        frac;
    logic signed [COL_WIDTH-1:0] q;
    logic signed [COL_WIDTH-1:0] n;
    logic signed [COL_WIDTH-1:0] k;
    logic signed [COL_WIDTH-1:0] res;
    frac = (e.rem != '0);
    q    = $signed({2'b00, e.nq});
    if (e.neg) begin
      q = -q - $signed({{(COL_WIDTH-1){1'b0}}, frac});
    end
    n = q + $signed({{(COL_WIDTH-COORD_WIDTH){e.ax[COORD_WIDTH-1]}}, e.ax});
    if (!n[COL_WIDTH-1]) begin
      res = n >>> FRAC_BITS;
    end else begin
      k   = frac ? (-n - $signed({{(COL_WIDTH-1){1'b0}}, 1'b1})) : -n;
      res = -(k >>> FRAC_BITS);
    end
    return res;
  endfunction

endpackage

// File: hdl/tss_front.sv
// front stage: sorts vertices by y, decides coverage and sets up both edge jobs
// depends on tss_pkg
`timescale 1ns / 1ps

module tss_front import tss_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  in_req_t in_req_i,
  output logic    push_valid_o,
  input  logic    push_full_i,
  output job_t    push_job_o
);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } vtx_t;

  logic front_valid_q, front_valid_d;
  job_t job_q, job_d;
  logic accept;

  vtx_t v0, v1, v2, t;
  logic signed [EXT_WIDTH-1:0] y0e, y1e, y2e, yq, row_e, span, tr2, along, ashort, dshort;
  logic upper, flat;

  // three compare-swaps, coverage and edge setup
  always_comb begin
    t  = '0;
    v0 = '{x: in_req_i.first_x,  y: in_req_i.first_y};
    v1 = '{x: in_req_i.second_x, y: in_req_i.second_y};
    v2 = '{x: in_req_i.third_x,  y: in_req_i.third_y};
    if ($signed(v1.y) < $signed(v0.y)) begin
      t = v0; v0 = v1; v1 = t;
    end
    if ($signed(v2.y) < $signed(v0.y)) begin
      t = v0; v0 = v2; v2 = t;
    end
    if ($signed(v2.y) < $signed(v1.y)) begin
      t = v1; v1 = v2; v2 = t;
    end
    y0e   = EXT_WIDTH'($signed(v0.y));
    y1e   = EXT_WIDTH'($signed(v1.y));
    y2e   = EXT_WIDTH'($signed(v2.y));
    yq    = EXT_WIDTH'($signed({in_req_i.row, {FRAC_BITS{1'b0}}}));
    row_e = EXT_WIDTH'($signed(in_req_i.row));
    span  = y2e - y0e;
    tr2   = y2e[EXT_WIDTH-1] ? -((-y2e) >>> FRAC_BITS) : (y2e >>> FRAC_BITS);

    job_d.covered = (span >= HALF) && (yq >= y0e) && !(row_e > tr2);

    // long edge top to bottom
    along          = yq - y0e;
    job_d.lng.ax   = v0.x;
    job_d.lng.dx   = DX_WIDTH'($signed(v2.x)) - DX_WIDTH'($signed(v0.x));
    job_d.lng.a    = along[EXT_WIDTH-1] ? '0 : along[A_WIDTH-1:0];
    job_d.lng.d    = span[COORD_WIDTH-1:0];

    // short edge, upper or lower half
    upper = (yq <= y1e);
    if (upper) begin
      dshort       = y1e - y0e;
      ashort       = yq - y0e;
      job_d.sht.ax = v0.x;
      job_d.sht.dx = DX_WIDTH'($signed(v1.x)) - DX_WIDTH'($signed(v0.x));
    end else begin
      dshort       = y2e - y1e;
      ashort       = yq - y1e;
      job_d.sht.ax = v1.x;
      job_d.sht.dx = DX_WIDTH'($signed(v2.x)) - DX_WIDTH'($signed(v1.x));
    end
    flat        = (dshort < HALF);
    job_d.sht.a = ashort[EXT_WIDTH-1] ? '0 : ashort[A_WIDTH-1:0];
    job_d.sht.d = dshort[COORD_WIDTH-1:0];
    // flat short edge: plain vertex x
    if (flat) begin
      job_d.sht.dx = '0;
      job_d.sht.a  = '0;
      job_d.sht.d  = COORD_WIDTH'(1);
    end
  end

  // handshake
  assign in_stall_o   = front_valid_q && push_full_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign push_valid_o = front_valid_q;
  assign push_job_o   = job_q;

  always_comb begin
    front_valid_d = front_valid_q;
    if (accept) begin
      front_valid_d = 1'b1;
    end else if (front_valid_q && !push_full_i) begin
      front_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else begin
      front_valid_q <= front_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

endmodule

// File: hdl/tss_queue.sv
// short job queue between front and back
// depends on tss_pkg
`timescale 1ns / 1ps

module tss_queue import tss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t pop_job_o
);

  job_t                  mem_q [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_WIDTH:0]   cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o    = (cnt_q == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_job_o = mem_q[rd_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wr_d  = do_push ? wr_q + QPTR_WIDTH'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPTR_WIDTH'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (QPTR_WIDTH+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (QPTR_WIDTH+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

// File: hdl/tss_back.sv
// back end: edge multiply, pipelined restoring divide, column truncation, min/max
// depends on tss_pkg
`timescale 1ns / 1ps

module tss_back import tss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  job_t     job_i,
  output logic     take_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  logic en;

  logic                  mv_q;
  div_t                  m_q, m_d;
  logic [MAG_WIDTH-1:0]  dvv_q;
  div_t                  dv_q [MAG_WIDTH];
  logic                  cv_q;
  logic                  cc_q;
  logic signed [COL_WIDTH-1:0] cl_q, cs_q;
  logic                  out_valid_q;
  out_rsp_t              out_q, out_d;

  function automatic div_edge_t mul_edge(edge_t e);
    div_edge_t                    r;
    logic signed [PROD_WIDTH-1:0] prod;
    logic signed [PROD_WIDTH-1:0] pm;
    prod  = PROD_WIDTH'($signed(e.dx) * $signed({1'b0, e.a}));
    r.neg = prod[PROD_WIDTH-1];
    pm    = r.neg ? -prod : prod;
    r.ax  = e.ax;
    r.d   = e.d;
    r.rem = '0;
    r.nq  = pm[MAG_WIDTH-1:0];
    return r;
  endfunction

  // whole pipeline moves together when the output can take a result
  assign en     = !out_valid_q || !out_stall_i;
  assign take_o = en;

  // multiply stage
  always_comb begin
    m_d.covered = job_i.covered;
    m_d.lng     = mul_edge(job_i.lng);
    m_d.sht     = mul_edge(job_i.sht);
  end

  // valid bits of all stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q        <= 1'b0;
      dvv_q       <= '0;
      cv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      mv_q        <= job_valid_i;
      dvv_q       <= {dvv_q[MAG_WIDTH-2:0], mv_q};
      cv_q        <= dvv_q[MAG_WIDTH-1];
      out_valid_q <= cv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q <= m_d;
    end
  end

  // one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= div_all(m_q);
      for (int i = 1; i < MAG_WIDTH; i++) begin
        dv_q[i] <= div_all(dv_q[i-1]);
      end
    end
  end

  // column stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      cc_q <= dv_q[MAG_WIDTH-1].covered;
      cl_q <= col_px(dv_q[MAG_WIDTH-1].lng);
      cs_q <= col_px(dv_q[MAG_WIDTH-1].sht);
    end
  end

  // min and max into the output register
  always_comb begin
    out_d = '0;
    if (cc_q) begin
      out_d.covered = 1'b1;
      if (cl_q < cs_q) begin
        out_d.span_left  = cl_q[OUT_WIDTH-1:0];
        out_d.span_right = cs_q[OUT_WIDTH-1:0];
      end else begin
        out_d.span_left  = cs_q[OUT_WIDTH-1:0];
        out_d.span_right = cl_q[OUT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: hdl/triangle_scanline_span_top.sv
// top level of the triangle scanline span block: front, queue and back
// depends on tss_pkg, tss_front, tss_queue, tss_back
//
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+-----------------------
// in       | input     | in_valid_i / in_stall_o | in_req_i  (in_req_t)
// out      | output    | out_valid_o/ out_stall_i| out_rsp_o (out_rsp_t)
//
// one request per clock sustained when nothing stalls; the divider is bit-per-stage,
// with one stage per numerator bit.
// reset clears all valid bits, pointers and the queue count; payload registers are not reset.
// an output stall on a held result freezes the back pipeline; the queue keeps taking
// requests until full, then the front register holds and in_stall_o rises.
`timescale 1ns / 1ps

module triangle_scanline_span_top import tss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  logic push_valid, q_full, q_valid, take;
  job_t push_job, pop_job;

  tss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .push_valid_o (push_valid),
    .push_full_i  (q_full),
    .push_job_o   (push_job)
  );

  tss_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_valid),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (take),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  tss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (pop_job),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the triangle scanline span block
// drives random and directed triangle/row requests and checks spans against an in-bench predictor
// depends on tss_pkg and triangle_scanline_span_top
`timescale 1ns / 1ps

module tb_top;
  import tss_pkg::*;

  localparam int LATENCY   = 2 * COORD_WIDTH + 6;
  localparam int WD_LIMIT  = 4000;
  localparam int N_RANDOM  = 1150;
  localparam int CALM_TAIL = 150;
  localparam longint UNIT  = 64'sd1 << FRAC_BITS;
  localparam longint HALFP = 64'sd1 << (FRAC_BITS - 1);

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  out_rsp_t out_rsp_o;

  in_req_t  pending_reqs[$];
  out_rsp_t span_expect[$];
  int       mismatches;
  int       accepted_in;
  int       accepted_out;
  int       covered_seen;
  int       idle_cnt;
  int       gap_left;
  int       stall_left;
  bit       stim_done;
  bit       calm;

  triangle_scanline_span_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // truncate n + f (0 <= f < 1, f > 0 when frac) toward zero after dividing by one pixel
  function automatic longint trunc_col(longint n, bit frac);
    longint k;
    if (n >= 0) return n / UNIT;
    k = frac ? -n - 1 : -n;
    return -(k / UNIT);
  endfunction

  // column of the line a->b at height yq, computed exactly
  function automatic longint edge_col(longint ax, longint ay, longint bx, longint by,
                                      longint yq);
    longint d;
    longint a;
    longint dx;
    longint m;
    longint q;
    longint r;
    d  = by - ay;
    a  = yq - ay;
    dx = bx - ax;
    if (d <= 0) return trunc_col(ax, 1'b0);
    if (a < 0) a = 0;
    m = dx < 0 ? -dx : dx;
    // magnitudes fit easily in 64 bits here
    q = (m * a) / d;
    r = (m * a) % d;
    if (dx >= 0) return trunc_col(ax + q, r != 0);
    if (r != 0) return trunc_col(ax - q - 1, 1'b1);
    return trunc_col(ax - q, 1'b0);
  endfunction

  // expected span for one request
  function automatic out_rsp_t predict_span(in_req_t rq);
    longint   vx[3];
    longint   vy[3];
    longint   t;
    longint   row;
    longint   yq;
    longint   xl;
    longint   xs;
    longint   lo;
    longint   hi;
    out_rsp_t rs;
    vx[0] = rq.first_x;  vy[0] = rq.first_y;
    vx[1] = rq.second_x; vy[1] = rq.second_y;
    vx[2] = rq.third_x;  vy[2] = rq.third_y;
    row = rq.row;
    if (vy[1] < vy[0]) begin
      t = vx[0]; vx[0] = vx[1]; vx[1] = t; t = vy[0]; vy[0] = vy[1]; vy[1] = t;
    end
    if (vy[2] < vy[0]) begin
      t = vx[0]; vx[0] = vx[2]; vx[2] = t; t = vy[0]; vy[0] = vy[2]; vy[2] = t;
    end
    if (vy[2] < vy[1]) begin
      t = vx[1]; vx[1] = vx[2]; vx[2] = t; t = vy[1]; vy[1] = vy[2]; vy[2] = t;
    end
    yq = row * UNIT;
    rs = '0;
    if (vy[2] - vy[0] < HALFP || yq < vy[0] || row > vy[2] / UNIT) return rs;
    xl = edge_col(vx[0], vy[0], vx[2], vy[2], yq);
    if (yq <= vy[1]) begin
      if (vy[1] - vy[0] < HALFP) xs = trunc_col(vx[0], 1'b0);
      else xs = edge_col(vx[0], vy[0], vx[1], vy[1], yq);
    end else begin
      if (vy[2] - vy[1] < HALFP) xs = trunc_col(vx[1], 1'b0);
      else xs = edge_col(vx[1], vy[1], vx[2], vy[2], yq);
    end
    lo = xl < xs ? xl : xs;
    hi = xl < xs ? xs : xl;
    rs.covered    = 1'b1;
    rs.span_left  = lo[OUT_WIDTH-1:0];
    rs.span_right = hi[OUT_WIDTH-1:0];
    return rs;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    return COORD_WIDTH'($urandom);
  endfunction

  // row somewhere inside or just around the y extent of the triangle
  function automatic logic signed [ROW_WIDTH-1:0] row_near(in_req_t rq);
    longint lo;
    longint hi;
    longint r;
    lo = rq.first_y;
    hi = rq.first_y;
    if (rq.second_y < lo) lo = rq.second_y;
    if (rq.third_y < lo) lo = rq.third_y;
    if (rq.second_y > hi) hi = rq.second_y;
    if (rq.third_y > hi) hi = rq.third_y;
    lo = (lo >>> FRAC_BITS) - 2;
    hi = (hi >>> FRAC_BITS) + 2;
    r  = lo + longint'($urandom_range(0, 32'(hi - lo)));
    return r[ROW_WIDTH-1:0];
  endfunction

  // triangle with vertices inside the row range, small or large
  function automatic in_req_t rand_triangle();
    in_req_t rq;
    int      span;
    int      cx;
    int      cy;
    span = ($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(4, 800);
    cx = $urandom_range(0, 60000) - 30000;
    cy = $urandom_range(0, 60000) - 30000;
    rq.first_x  = COORD_WIDTH'(cx + $urandom_range(0, span) - span / 2);
    rq.first_y  = COORD_WIDTH'(cy + $urandom_range(0, span) - span / 2);
    rq.second_x = COORD_WIDTH'(cx + $urandom_range(0, span) - span / 2);
    rq.second_y = COORD_WIDTH'(cy + $urandom_range(0, span) - span / 2);
    rq.third_x  = COORD_WIDTH'(cx + $urandom_range(0, span) - span / 2);
    rq.third_y  = COORD_WIDTH'(cy + $urandom_range(0, span) - span / 2);
    // flat short edges and thin triangles now and then
    if ($urandom_range(0, 5) == 0) rq.second_y = rq.first_y + COORD_WIDTH'($urandom_range(0, 7));
    if ($urandom_range(0, 5) == 0) rq.third_y = rq.second_y - COORD_WIDTH'($urandom_range(0, 7));
    rq.row = row_near(rq);
    return rq;
  endfunction

  function automatic in_req_t make_req(int x0, int y0, int x1, int y1, int x2, int y2, int r);
    in_req_t rq;
    rq.first_x  = COORD_WIDTH'(x0);
    rq.first_y  = COORD_WIDTH'(y0);
    rq.second_x = COORD_WIDTH'(x1);
    rq.second_y = COORD_WIDTH'(y1);
    rq.third_x  = COORD_WIDTH'(x2);
    rq.third_y  = COORD_WIDTH'(y2);
    rq.row      = ROW_WIDTH'(r);
    return rq;
  endfunction

  // stimulus: directed corners then random triangles
  initial begin
    in_req_t rq;
    // plain triangle, several rows
    pending_reqs.push_back(make_req(0, 0, 160, 80, 40, 160, 0));
    pending_reqs.push_back(make_req(0, 0, 160, 80, 40, 160, 5));
    pending_reqs.push_back(make_req(0, 0, 160, 80, 40, 160, 10));
    pending_reqs.push_back(make_req(0, 0, 160, 80, 40, 160, 11));
    // degenerate spread and exactly half a pixel
    pending_reqs.push_back(make_req(0, 16, 100, 23, 50, 20, 1));
    pending_reqs.push_back(make_req(0, 16, 100, 24, 50, 20, 1));
    // flat top and flat bottom short edges
    pending_reqs.push_back(make_req(-40, 32, 200, 35, 80, 200, 2));
    pending_reqs.push_back(make_req(-40, 32, 200, 197, 80, 200, 12));
    // negative bottom y, row just below the bottom vertex
    pending_reqs.push_back(make_req(-300, -120, 300, -40, 10, -70, -2));
    pending_reqs.push_back(make_req(-300, -120, 300, -33, 10, -70, -2));
    // row above and below the triangle
    pending_reqs.push_back(make_req(0, 0, 160, 80, 40, 160, -1));
    pending_reqs.push_back(make_req(0, 0, 160, 80, 40, 160, 2047));
    // coordinate extremes, wide columns
    pending_reqs.push_back(make_req(-32768, -32768, 32767, 32767, -32768, 32767, 0));
    pending_reqs.push_back(make_req(32767, -32768, -32768, 0, 32767, 32767, -2048));
    pending_reqs.push_back(make_req(-32768, -32768, 32767, 32767, 32767, -32768, 2047));
    pending_reqs.push_back(make_req(32767, 32767, 32767, 32767, 32767, 32767, 2047));
    pending_reqs.push_back(make_req(-1, -1, -1, -1, -1, -1, -1));
    // equal y values exercise sort ties
    pending_reqs.push_back(make_req(10, 48, 90, 48, 50, 48, 3));
    pending_reqs.push_back(make_req(10, 48, 90, 48, 50, 160, 3));
    pending_reqs.push_back(make_req(-500, -800, 400, -1, 0, -800, -1));
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        // raw noise over every bit
        rq.first_x  = rand_coord(); rq.first_y  = rand_coord();
        rq.second_x = rand_coord(); rq.second_y = rand_coord();
        rq.third_x  = rand_coord(); rq.third_y  = rand_coord();
        rq.row      = ROW_WIDTH'($urandom);
      end else begin
        rq = rand_triangle();
      end
      pending_reqs.push_back(rq);
    end
    stim_done = 1'b1;
  end

  // reset
  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        span_expect.push_back(predict_span(in_req_i));
        accepted_in <= accepted_in + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pending_reqs.size() > 0) begin
          in_valid_i <= 1'b1;
          in_req_i   <= pending_reqs.pop_front();
          if (!calm && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // response monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t exp_rsp;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        accepted_out <= accepted_out + 1;
        if (span_expect.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected response %p", out_rsp_o);
        end else begin
          exp_rsp = span_expect.pop_front();
          if (exp_rsp.covered) covered_seen <= covered_seen + 1;
          if (out_rsp_o.covered !== exp_rsp.covered ||
              out_rsp_o.span_left !== exp_rsp.span_left ||
              out_rsp_o.span_right !== exp_rsp.span_right) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("span mismatch: expected cov=%0d l=%0d r=%0d, got cov=%0d l=%0d r=%0d",
                       exp_rsp.covered, exp_rsp.span_left, exp_rsp.span_right,
                       out_rsp_o.covered, out_rsp_o.span_left, out_rsp_o.span_right);
          end
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 3);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // calm tail with no idling once few requests remain
  always @(posedge clk_i) begin
    if (stim_done && pending_reqs.size() < CALM_TAIL) calm <= 1'b1;
  end

  // watchdog: cycles without any accepted request or response
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cnt);
      $display("triangle_scanline_span_top regression: fail");
      $finish;
    end
  end

  // end of run: all requests sent and accepted, then drain the responses
  initial begin
    wait (stim_done);
    wait (pending_reqs.size() == 0 && !in_valid_i);
    wait (span_expect.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("run covered %0d requests and %0d responses, %0d of them covered rows",
             accepted_in, accepted_out, covered_seen);
    if (mismatches == 0 && span_expect.size() == 0) begin
      $display("triangle_scanline_span_top regression: pass");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatches, span_expect.size());
      $display("triangle_scanline_span_top regression: fail");
    end
    $finish;
  end

endmodule
